/* hdl/swsc_pkg.sv */
// swsc_pkg: shared codes for the sliding window sender control unit
// phase codes, event opcodes and packet flag values; no dependencies
package swsc_pkg;

   // protocol phases
   localparam logic [2:0] PH_START    = 3'd0;
   localparam logic [2:0] PH_FILENAME = 3'd1;
   localparam logic [2:0] PH_SEND     = 3'd2;
   localparam logic [2:0] PH_WAIT     = 3'd3;
   localparam logic [2:0] PH_SHUTDOWN = 3'd4;

   // event opcodes
   localparam logic [1:0] OP_TRANSMIT = 2'd0;
   localparam logic [1:0] OP_CONTROL  = 2'd1;
   localparam logic [1:0] OP_TIMEOUT  = 2'd2;

   // received packet flags
   localparam logic [7:0] RX_FLAG_RESTART = 8'd1;
   localparam logic [7:0] RX_FLAG_SREJ    = 8'd6;
   localparam logic [7:0] RX_FLAG_RESEND  = 8'd7;
   localparam logic [7:0] RX_FLAG_END     = 8'd11;

   // transmitted packet flags
   localparam logic [7:0] TX_FLAG_SETUP_ACK = 8'd2;
   localparam logic [7:0] TX_FLAG_DATA      = 8'd3;
   localparam logic [7:0] TX_FLAG_FILE_OK   = 8'd8;

   // register map
   localparam int unsigned CSR_ADDR_W         = 3;
   localparam logic [7:0]  RETRY_LIMIT_RESET  = 8'd11;

endpackage

/* hdl/sliding_window_sender_control_unit.sv */
// sliding_window_sender_control_unit: sender side control of a sliding-window
// file transfer (go-back-n with selective reject); depends on swsc_pkg
//
// Usage:
//   req channel: one event per beat (transmit opportunity, received control
//     packet with flag, sequence, window byte and checksum verdict, or an
//     ack timeout). rsp channel: exactly one result beat per event with the
//     packet command (flag, sequence, buffer slot), the count of chunks to
//     fetch after a window shift and the shutdown indication.
//   csr port: retry_limit at byte address 0, written in the apb access phase.
//   A req beat passes through an input register, then the phase and window
//     update logic feeding the result register.
//   Throughput is one event per cycle while no result is held under rsp_stall;
//     the state registers are rewritten in the same cycle the result is formed, so back-to-back events chain.
//   When rsp_stall is high with a result held, the input register keeps its
//     event and req_stall rises; a new event is still taken while the input
//     register is empty.
//   Reset clears the phase to start, the window edges, sequence and retry
//     count to zero, retry_limit to 11 and both valid flags.
module sliding_window_sender_control_unit #(
   parameter int MAX_SLOTS = 254
) (
   input  logic                               clock,
   input  logic                               reset,
   // event channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_opcode,
   input  logic [7:0]                         req_rx_flag,
   input  logic [31:0]                        req_rx_seq,
   input  logic [7:0]                         req_rx_window,
   input  logic                               req_rx_checksum_ok,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_tx_valid,
   output logic [7:0]                         rsp_tx_flag,
   output logic [31:0]                        rsp_tx_seq,
   output logic [7:0]                         rsp_tx_slot,
   output logic [7:0]                         rsp_fetch_count,
   output logic                               rsp_shutdown,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [swsc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import swsc_pkg::*;

   localparam logic [7:0] MaxSlots = 8'(MAX_SLOTS);

   // configuration
   logic [7:0]  retry_limit_ff;
   logic        csr_write;

   // input register
   logic        in_valid_ff;
   logic [1:0]  in_opcode_ff;
   logic [7:0]  in_flag_ff;
   logic [31:0] in_seq_ff;
   logic [7:0]  in_window_ff;
   logic        in_ok_ff;
   logic        advance;
   logic        take_in;

   // protocol state
   logic [2:0]  phase_ff, phase_in;
   logic [31:0] low_edge_ff, low_edge_in;
   logic [7:0]  window_slots_ff, window_slots_in;
   logic [31:0] next_seq_ff, next_seq_in;
   logic [7:0]  retry_count_ff, retry_count_in;

   // result register
   logic        out_valid_ff;
   logic        tx_valid_ff, tx_valid_in;
   logic [7:0]  tx_flag_ff, tx_flag_in;
   logic [31:0] tx_seq_ff, tx_seq_in;
   logic [7:0]  tx_slot_ff, tx_slot_in;
   logic [7:0]  fetch_count_ff, fetch_count_in;

   // helper terms
   logic [31:0] send_off;
   logic        send_in_win;
   logic [31:0] ack_shift;
   logic        ack_in_win;
   logic        retry_hit;
   logic [7:0]  retry_inc;
   logic        retry_inc_hit;
   logic [7:0]  win_minus1;
   logic [7:0]  win_slots;

   // apb register access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && !csr_paddr[CSR_ADDR_W-1];
   assign csr_prdata = csr_paddr[CSR_ADDR_W-1] ? 32'd0 : {24'd0, retry_limit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_LIMIT_RESET;
      end else if (csr_write) begin
         retry_limit_ff <= csr_pwdata[7:0];
      end
   end

   // handshake: input register drains when the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take_in   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take_in) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         in_opcode_ff <= req_opcode;
         in_flag_ff   <= req_rx_flag;
         in_seq_ff    <= req_rx_seq;
         in_window_ff <= req_rx_window;
         in_ok_ff     <= req_rx_checksum_ok;
      end
   end

   // window arithmetic
   assign send_off      = next_seq_ff - low_edge_ff;
   assign send_in_win   = send_off < {24'd0, window_slots_ff};
   assign ack_shift     = in_seq_ff - low_edge_ff;
   assign ack_in_win    = ack_shift <= {24'd0, window_slots_ff};
   assign retry_hit     = retry_count_ff >= retry_limit_ff;
   assign retry_inc     = (retry_count_ff == 8'hFF) ? 8'hFF : retry_count_ff + 8'd1;
   assign retry_inc_hit = retry_inc >= retry_limit_ff;
   assign win_minus1    = (in_window_ff == 8'd0) ? 8'd0 : in_window_ff - 8'd1;
   assign win_slots     = (win_minus1 > MaxSlots) ? MaxSlots : win_minus1;

   // phase and window update for the event in the input register
   always_comb begin
      phase_in        = phase_ff;
      low_edge_in     = low_edge_ff;
      window_slots_in = window_slots_ff;
      next_seq_in     = next_seq_ff;
      retry_count_in  = retry_count_ff;
      tx_valid_in     = 1'b0;
      tx_flag_in      = 8'd0;
      tx_seq_in       = 32'd0;
      tx_slot_in      = 8'd0;
      fetch_count_in  = 8'd0;

      unique case (phase_ff)
         PH_START: begin
            if (in_opcode_ff == OP_CONTROL && in_ok_ff) begin
               tx_valid_in = 1'b1;
               tx_flag_in  = TX_FLAG_SETUP_ACK;
               phase_in    = PH_FILENAME;
            end
         end
         PH_FILENAME: begin
            if (in_opcode_ff == OP_CONTROL && in_ok_ff) begin
               if (in_flag_ff == RX_FLAG_RESTART) begin
                  phase_in = PH_START;
               end else begin
                  window_slots_in = win_slots;
                  low_edge_in     = 32'd0;
                  fetch_count_in  = win_slots;
                  tx_valid_in     = 1'b1;
                  tx_flag_in      = TX_FLAG_FILE_OK;
                  phase_in        = PH_SEND;
               end
            end
         end
         PH_SEND, PH_WAIT: begin
            priority if (phase_ff == PH_SEND && in_opcode_ff == OP_TRANSMIT) begin
               // send next data chunk while it lies inside the window
               if (send_in_win) begin
                  tx_valid_in = 1'b1;
                  tx_flag_in  = TX_FLAG_DATA;
                  tx_seq_in   = next_seq_ff;
                  tx_slot_in  = send_off[7:0];
                  next_seq_in = next_seq_ff + 32'd1;
                  phase_in    = (send_off[7:0] + 8'd1 < window_slots_ff) ? PH_SEND : PH_WAIT;
                  if (send_off[7:0] + 8'd1 == window_slots_ff) begin
                     phase_in = PH_SEND;
                  end
               end else begin
                  phase_in = PH_WAIT;
               end
            end else if (retry_hit) begin
               // out of retries: control packet (or timeout while waiting) ends it
               if (in_opcode_ff == OP_CONTROL ||
                   (phase_ff == PH_WAIT && in_opcode_ff == OP_TIMEOUT)) begin
                  phase_in = PH_SHUTDOWN;
               end
            end else if (phase_ff == PH_WAIT && in_opcode_ff == OP_TIMEOUT) begin
               // go back to the low edge and resend its slot
               next_seq_in    = low_edge_ff;
               tx_valid_in    = 1'b1;
               tx_flag_in     = TX_FLAG_DATA;
               tx_seq_in      = low_edge_ff;
               retry_count_in = retry_inc;
               if (retry_inc_hit) begin
                  phase_in = PH_SHUTDOWN;
               end
            end else if (in_opcode_ff == OP_CONTROL) begin
               // received control packet
               priority if (!in_ok_ff) begin
                  retry_count_in = retry_inc;
                  if (retry_inc_hit) begin
                     phase_in = PH_SHUTDOWN;
                  end
               end else if (in_flag_ff == RX_FLAG_END) begin
                  phase_in = PH_SHUTDOWN;
               end else begin
                  if (in_flag_ff == RX_FLAG_SREJ) begin
                     next_seq_in = in_seq_ff;
                  end
                  if (in_flag_ff == RX_FLAG_RESEND) begin
                     tx_valid_in = 1'b1;
                     tx_flag_in  = TX_FLAG_FILE_OK;
                     next_seq_in = 32'd0;
                  end
                  if (ack_in_win) begin
                     low_edge_in    = in_seq_ff;
                     fetch_count_in = ack_shift[7:0];
                  end
                  retry_count_in = 8'd0;
                  phase_in       = PH_SEND;
               end
            end else begin
               // events this phase does not expect are ignored
               phase_in = phase_ff;
            end
         end
         PH_SHUTDOWN: begin
            phase_in = PH_SHUTDOWN;
         end
         default: begin
            phase_in = PH_SHUTDOWN;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_START;
         low_edge_ff     <= 32'd0;
         window_slots_ff <= 8'd0;
         next_seq_ff     <= 32'd0;
         retry_count_ff  <= 8'd0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         low_edge_ff     <= low_edge_in;
         window_slots_ff <= window_slots_in;
         next_seq_ff     <= next_seq_in;
         retry_count_ff  <= retry_count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tx_valid_ff    <= tx_valid_in;
         tx_flag_ff     <= tx_flag_in;
         tx_seq_ff      <= tx_seq_in;
         tx_slot_ff     <= tx_slot_in;
         fetch_count_ff <= fetch_count_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_tx_valid    = tx_valid_ff;
   assign rsp_tx_flag     = tx_flag_ff;
   assign rsp_tx_seq      = tx_seq_ff;
   assign rsp_tx_slot     = tx_slot_ff;
   assign rsp_fetch_count = fetch_count_ff;
   assign rsp_shutdown    = (phase_ff == PH_SHUTDOWN);

endmodule

/* tb/tb.sv */
// tb: self-checking bench for the sliding window sender control unit
// drives events, apb writes of retry_limit and a stalling result sink; depends on swsc_pkg
`timescale 1ns / 1ps

module tb;
   import swsc_pkg::*;

   localparam int unsigned WINDOW_MAX = 254;
   localparam logic [7:0] RX_FLAG_RR = 8'd5;
   localparam logic [swsc_pkg::CSR_ADDR_W-1:0] CSR_ADDR_RETRY_LIMIT = '0;
   localparam int unsigned ITEMS_PER_PHASE = 212;
   localparam int unsigned NUM_PHASES = 8;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  rx_flag;
      logic [31:0] rx_seq;
      logic [7:0]  rx_window;
      logic        rx_checksum_ok;
   } arq_event_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_flag;
      logic [31:0] tx_seq;
      logic [7:0]  tx_slot;
      logic [7:0]  fetch_count;
      logic        shutdown;
   } tx_cmd_type;

   // tracks the sender protocol state and queues the command each event should produce
   class arq_sender_tracker;
      logic [2:0]  cur_phase;
      logic [31:0] win_base;
      logic [7:0]  win_slots;
      logic [31:0] seq_next;
      logic [7:0]  fail_count;
      logic [7:0]  fail_limit;
      tx_cmd_type  due_results[$];
      int          n_events;
      int          n_checked;
      int          n_errors;

      function new();
         cur_phase  = PH_START;
         win_base   = '0;
         win_slots  = '0;
         seq_next   = '0;
         fail_count = '0;
         fail_limit = RETRY_LIMIT_RESET;
         n_events   = 0;
         n_checked  = 0;
         n_errors   = 0;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function tx_cmd_type with_packet(tx_cmd_type r, logic [7:0] flag, logic [31:0] seq,
                                       logic [7:0] slot);
         r.tx_valid = 1'b1;
         r.tx_flag  = flag;
         r.tx_seq   = seq;
         r.tx_slot  = slot;
         return r;
      endfunction

      // one more failed wait, shut down once the limit is met
      function void account_failure();
         if (fail_count < 8'hff) fail_count++;
         if (fail_count >= fail_limit) cur_phase = PH_SHUTDOWN;
      endfunction

      // received control packet in send or wait phase
      function void apply_control(arq_event_type ev, inout tx_cmd_type r);
         logic [31:0] shift;
         if (!ev.rx_checksum_ok) begin
            account_failure();
            return;
         end
         if (ev.rx_flag == RX_FLAG_END) begin
            cur_phase = PH_SHUTDOWN;
            return;
         end
         if (ev.rx_flag == RX_FLAG_SREJ) seq_next = ev.rx_seq;
         if (ev.rx_flag == RX_FLAG_RESEND) begin
            r = with_packet(r, TX_FLAG_FILE_OK, 32'd0, 8'd0);
            seq_next = '0;
         end
         // slide the window when the ack falls inside it
         shift = ev.rx_seq - win_base;
         if (shift <= {24'd0, win_slots}) begin
            win_base = ev.rx_seq;
            r.fetch_count = shift[7:0];
         end
         fail_count = '0;
         cur_phase = PH_SEND;
      endfunction

      function void take_event(arq_event_type ev);
         tx_cmd_type  r;
         logic [31:0] off;
         logic [7:0]  slots;
         r = '0;
         case (cur_phase)
            PH_START: begin
               if (ev.opcode == OP_CONTROL && ev.rx_checksum_ok) begin
                  r = with_packet(r, TX_FLAG_SETUP_ACK, 32'd0, 8'd0);
                  cur_phase = PH_FILENAME;
               end
            end
            PH_FILENAME: begin
               if (ev.opcode == OP_CONTROL && ev.rx_checksum_ok) begin
                  if (ev.rx_flag == RX_FLAG_RESTART) begin
                     cur_phase = PH_START;
                  end else begin
                     slots = (ev.rx_window == 8'd0) ? 8'd0 : ev.rx_window - 8'd1;
                     if (slots > WINDOW_MAX) slots = 8'(WINDOW_MAX);
                     win_slots = slots;
                     win_base = '0;
                     r.fetch_count = slots;
                     r = with_packet(r, TX_FLAG_FILE_OK, 32'd0, 8'd0);
                     cur_phase = PH_SEND;
                  end
               end
            end
            PH_SEND: begin
               if (ev.opcode == OP_TRANSMIT) begin
                  off = seq_next - win_base;
                  if (off < {24'd0, win_slots}) begin
                     r = with_packet(r, TX_FLAG_DATA, seq_next, off[7:0]);
                     seq_next++;
                     cur_phase = (off + 32'd1 <= {24'd0, win_slots}) ? PH_SEND : PH_WAIT;
                  end else begin
                     cur_phase = PH_WAIT;
                  end
               end else if (ev.opcode == OP_CONTROL) begin
                  if (fail_count >= fail_limit) cur_phase = PH_SHUTDOWN;
                  else apply_control(ev, r);
               end
            end
            PH_WAIT: begin
               if (fail_count >= fail_limit) begin
                  if (ev.opcode == OP_CONTROL || ev.opcode == OP_TIMEOUT)
                     cur_phase = PH_SHUTDOWN;
               end else if (ev.opcode == OP_TIMEOUT) begin
                  // go back to the low edge and resend it
                  seq_next = win_base;
                  r = with_packet(r, TX_FLAG_DATA, win_base, 8'd0);
                  account_failure();
               end else if (ev.opcode == OP_CONTROL) begin
                  apply_control(ev, r);
               end
            end
            default: cur_phase = PH_SHUTDOWN;
         endcase
         r.shutdown = (cur_phase == PH_SHUTDOWN);
         due_results.push_back(r);
         n_events++;
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            n_errors++;
         end
      endfunction

      function void match_result(tx_cmd_type act);
         tx_cmd_type exp_r;
         if (due_results.size() == 0) begin
            $error("result beat with no event outstanding");
            n_errors++;
            return;
         end
         exp_r = due_results.pop_front();
         compare_field("tx_valid", 32'(exp_r.tx_valid), 32'(act.tx_valid));
         compare_field("tx_flag", 32'(exp_r.tx_flag), 32'(act.tx_flag));
         compare_field("tx_seq", exp_r.tx_seq, act.tx_seq);
         compare_field("tx_slot", 32'(exp_r.tx_slot), 32'(act.tx_slot));
         compare_field("fetch_count", 32'(exp_r.fetch_count), 32'(act.fetch_count));
         compare_field("shutdown", 32'(exp_r.shutdown), 32'(act.shutdown));
         n_checked++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [7:0]  req_rx_flag = '0;
   logic [31:0] req_rx_seq = '0;
   logic [7:0]  req_rx_window = '0;
   logic        req_rx_checksum_ok = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_flag;
   logic [31:0] rsp_tx_seq;
   logic [7:0]  rsp_tx_slot;
   logic [7:0]  rsp_fetch_count;
   logic        rsp_shutdown;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [swsc_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   arq_sender_tracker sb;
   int idle_pct = 0;
   int stall_pct = 0;
   int limit_writes = 0;

   sliding_window_sender_control_unit #(.MAX_SLOTS(WINDOW_MAX)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_rx_flag(req_rx_flag), .req_rx_seq(req_rx_seq), .req_rx_window(req_rx_window),
      .req_rx_checksum_ok(req_rx_checksum_ok),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_tx_valid(rsp_tx_valid),
      .rsp_tx_flag(rsp_tx_flag), .rsp_tx_seq(rsp_tx_seq), .rsp_tx_slot(rsp_tx_slot),
      .rsp_fetch_count(rsp_fetch_count), .rsp_shutdown(rsp_shutdown),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result sink: check each accepted beat, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.match_result({rsp_tx_valid, rsp_tx_flag, rsp_tx_seq, rsp_tx_slot,
                          rsp_fetch_count, rsp_shutdown});
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic arq_event_type mk_event(logic [1:0] op, logic [7:0] flag,
                                              logic [31:0] seq, logic [7:0] win, logic ok);
      arq_event_type ev;
      ev.opcode = op;
      ev.rx_flag = flag;
      ev.rx_seq = seq;
      ev.rx_window = win;
      ev.rx_checksum_ok = ok;
      return ev;
   endfunction

   function automatic arq_event_type noise_event();
      return mk_event(2'($urandom_range(2)), 8'($urandom), $urandom, 8'($urandom),
                      1'($urandom));
   endfunction

   // window byte of the filename packet, mostly small windows
   function automatic logic [7:0] pick_window();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 8'd0;
      if (r < 20) return 8'd255;
      if (r < 30) return 8'd1;
      return 8'($urandom_range(12, 2));
   endfunction

   function automatic arq_event_type next_random_event();
      int          r;
      logic [31:0] span;
      logic [31:0] seq_in;
      logic [7:0]  other;
      bit          may_fail;
      r = $urandom_range(99);
      case (sb.cur_phase)
         PH_START: begin
            if (r < 70) return mk_event(OP_CONTROL, 8'($urandom), $urandom, 8'($urandom), 1'b1);
            return noise_event();
         end
         PH_FILENAME: begin
            if (r < 15) return mk_event(OP_CONTROL, RX_FLAG_RESTART, $urandom, 8'($urandom),
                                        1'b1);
            if (r < 80) begin
               other = 8'($urandom);
               if (other == RX_FLAG_RESTART) other = 8'd0;
               return mk_event(OP_CONTROL, other, $urandom, pick_window(), 1'b1);
            end
            return noise_event();
         end
         PH_SEND, PH_WAIT: begin
            span = sb.seq_next - sb.win_base;
            if (span > {24'd0, sb.win_slots}) span = {24'd0, sb.win_slots};
            seq_in = sb.win_base + $urandom_range(span);
            may_fail = (int'(sb.fail_count) + 1 < int'(sb.fail_limit));
            other = 8'($urandom);
            if (other == RX_FLAG_RR || other == RX_FLAG_SREJ || other == RX_FLAG_RESEND ||
                other == RX_FLAG_END)
               other = RX_FLAG_RESTART;
            if (r < 45) return mk_event(OP_TRANSMIT, 8'($urandom), $urandom, 8'($urandom),
                                        1'($urandom));
            if (r < 65) return mk_event(OP_CONTROL, RX_FLAG_RR, seq_in, 8'($urandom), 1'b1);
            if (r < 70) return mk_event(OP_CONTROL, RX_FLAG_RR, $urandom, 8'($urandom), 1'b1);
            if (r < 76) return mk_event(OP_CONTROL, RX_FLAG_SREJ, seq_in, 8'($urandom), 1'b1);
            if (r < 78) return mk_event(OP_CONTROL, RX_FLAG_SREJ, $urandom, 8'($urandom), 1'b1);
            if (r < 80) return mk_event(OP_CONTROL, RX_FLAG_RESEND, seq_in, 8'($urandom), 1'b1);
            if (r < 84) return mk_event(OP_CONTROL, other, seq_in, 8'($urandom), 1'b1);
            if (may_fail && r < 94)
               return mk_event(OP_TIMEOUT, 8'($urandom), $urandom, 8'($urandom), 1'($urandom));
            if (may_fail)
               return mk_event(OP_CONTROL, 8'($urandom), $urandom, 8'($urandom), 1'b0);
            return mk_event(OP_CONTROL, RX_FLAG_RR, seq_in, 8'($urandom), 1'b1);
         end
         default: return noise_event();
      endcase
   endfunction

   // one event beat, with a random sender gap ahead of it
   task automatic drive_event(input arq_event_type ev);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_opcode <= ev.opcode;
      req_rx_flag <= ev.rx_flag;
      req_rx_seq <= ev.rx_seq;
      req_rx_window <= ev.rx_window;
      req_rx_checksum_ok <= ev.rx_checksum_ok;
      do @(posedge clock); while (req_stall);
      sb.take_event(ev);
   endtask

   // drop valid and let every outstanding result drain
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle
   task automatic csr_write_retry_limit(input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_RETRY_LIMIT;
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.fail_limit = value;
      limit_writes++;
   endtask

   task automatic set_idling(input int mode);
      case (mode % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 67; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 67; end
         default: begin idle_pct = 14; stall_pct = 14; end
      endcase
   endtask

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic [7:0] limits [NUM_PHASES];
      int         ending;
      int         n;
      string      ending_name;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_idling(3);

      // directed: session setup with ignored and rejected packets
      drive_event(mk_event(OP_TRANSMIT, 8'd0, 32'd0, 8'd0, 1'b0));
      drive_event(mk_event(OP_TIMEOUT, 8'hff, 32'hffff_ffff, 8'hff, 1'b1));
      drive_event(mk_event(OP_CONTROL, 8'hff, 32'hffff_ffff, 8'hff, 1'b0));
      drive_event(mk_event(OP_CONTROL, 8'd0, 32'd0, 8'd0, 1'b1));
      drive_event(mk_event(OP_CONTROL, RX_FLAG_RR, 32'd0, 8'd4, 1'b0));
      drive_event(mk_event(OP_TRANSMIT, 8'd0, 32'd0, 8'd4, 1'b1));
      drive_event(mk_event(OP_CONTROL, RX_FLAG_RESTART, 32'd0, 8'd0, 1'b1));
      drive_event(mk_event(OP_CONTROL, RX_FLAG_END, 32'd0, 8'd0, 1'b1));
      drive_event(mk_event(OP_CONTROL, 8'd0, 32'h1234, pick_window(), 1'b1));
      // directed: data, acks and the wait phase corner cases
      repeat (3) drive_event(mk_event(OP_TRANSMIT, 8'd0, 32'd0, 8'd0, 1'b1));
      drive_event(mk_event(OP_TIMEOUT, 8'd0, 32'd0, 8'd0, 1'b1));
      drive_event(mk_event(OP_CONTROL, RX_FLAG_RR, sb.win_base + 32'd1, 8'd0, 1'b1));
      drive_event(mk_event(OP_CONTROL, 8'hff, 32'hffff_ffff, 8'hff, 1'b1));
      drive_event(mk_event(OP_CONTROL, RX_FLAG_SREJ, sb.win_base, 8'd0, 1'b1));
      drive_event(mk_event(OP_CONTROL, RX_FLAG_RESEND, 32'd0, 8'd0, 1'b1));
      drive_event(mk_event(OP_CONTROL, RX_FLAG_END, 32'd0, 8'd0, 1'b0));
      repeat (2) drive_event(mk_event(OP_TRANSMIT, 8'd0, 32'd0, 8'd0, 1'b1));
      drive_event(mk_event(OP_TIMEOUT, 8'd0, 32'd0, 8'd0, 1'b1));
      drive_event(mk_event(OP_CONTROL, RX_FLAG_RR, sb.seq_next, 8'd0, 1'b1));

      // random phases, each with its own retry limit and idling pattern
      limits = '{8'd1, 8'd255, 8'($urandom_range(254, 2)), 8'd2, 8'($urandom_range(254, 2)),
                 8'd255, 8'($urandom_range(254, 2)), 8'd11};
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         csr_write_retry_limit(limits[p]);
         set_idling(p);
         repeat (ITEMS_PER_PHASE) drive_event(next_random_event());
         // clean ack so no failure count carries into the next limit
         if (sb.cur_phase == PH_SEND || sb.cur_phase == PH_WAIT)
            drive_event(mk_event(OP_CONTROL, RX_FLAG_RR, sb.win_base, 8'($urandom), 1'b1));
      end

      // close the session one of three ways when in the send or wait phase
      ending = $urandom_range(2);
      set_idling(3);
      if (sb.cur_phase == PH_SEND || sb.cur_phase == PH_WAIT) begin
         if (ending == 0) begin
            ending_name = "end flag";
            drive_event(mk_event(OP_CONTROL, RX_FLAG_END, $urandom, 8'($urandom), 1'b1));
         end else if (ending == 1) begin
            ending_name = "retry exhaustion";
            n = 0;
            while (sb.cur_phase != PH_SHUTDOWN && n < 600) begin
               if (sb.cur_phase == PH_WAIT)
                  drive_event(mk_event(OP_TIMEOUT, 8'd0, 32'd0, 8'd0, 1'b1));
               else
                  drive_event(mk_event(OP_CONTROL, RX_FLAG_RR, sb.win_base, 8'd0, 1'b0));
               n++;
            end
         end else begin
            ending_name = "retry limit lowered below the count";
            repeat (2) drive_event(mk_event(OP_CONTROL, RX_FLAG_RR, sb.win_base, 8'd0, 1'b0));
            settle();
            csr_write_retry_limit(8'd1);
            drive_event(mk_event(OP_TRANSMIT, 8'd0, 32'd0, 8'd0, 1'b1));
            drive_event(mk_event(OP_TIMEOUT, 8'd0, 32'd0, 8'd0, 1'b1));
            drive_event(mk_event(OP_CONTROL, RX_FLAG_RR, sb.win_base, 8'd0, 1'b1));
         end
      end else begin
         ending_name = "none";
      end
      repeat (10) drive_event(noise_event());

      settle();
      repeat (5) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected result beats never arrived", sb.pending());
         sb.n_errors++;
      end
      $display("tb: %0d events, %0d result beats checked, %0d retry limit writes",
               sb.n_events, sb.n_checked, limit_writes);
      $display("tb: window of %0d slots, session closed by %s", sb.win_slots, ending_name);
      if (sb.n_errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* filelist.f */
hdl/swsc_pkg.sv
hdl/sliding_window_sender_control_unit.sv
tb/tb.sv
